// ===== rtl/esd_pkg.sv =====
// esd_pkg: shared types for the escape sequence decoder
// decode mode, result word and push bundle between decode and output queue
// no dependencies
package esd_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_DEC  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [15:0] length;
    logic        last;
    logic        has_byte;
    logic [7:0]  data;
  } result_t;

  // up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] n;
    result_t    r1;
    result_t    r0;
  } push_t;

endpackage

// ===== rtl/esd_decode.sv =====
// esd_decode: escape decode state and per-word result generation
// produces up to two result words per accepted input word
// depends on esd_pkg
module esd_decode import esd_pkg::*; #(
  parameter int unsigned LENGTH_MAX = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output push_t      push_o
);

  localparam logic [15:0] CountCap = (LENGTH_MAX < 65535) ? LENGTH_MAX[15:0] : 16'hFFFF;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChA      = 8'h61;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoF    = 8'h66;

  localparam logic [7:0] CodeTab  = 8'h09;
  localparam logic [7:0] CodeLf   = 8'h0A;
  localparam logic [7:0] CodeCr   = 8'h0D;
  localparam logic [7:0] CodeBs   = 8'h08;
  localparam logic [7:0] CodeFf   = 8'h0C;
  localparam logic [7:0] CodeBel  = 8'h07;

  mode_e       mode_q, mode_d;
  logic [7:0]  value_q, value_d;
  logic [1:0]  count_q, count_d;
  logic [15:0] bytes_q, bytes_d;

  logic        is_dec, is_hex;
  logic [3:0]  dec_d, hex_d;
  logic [7:0]  hex_acc, dec_acc;
  logic        k0_byte, k0_end, k1_byte, k1_end;
  logic [7:0]  b0, b1;
  logic [15:0] len0, len1;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v < CountCap) ? v + 16'd1 : v;
  endfunction

  assign is_dec = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign dec_d  = byte_i[3:0];

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (is_dec) begin
      hex_d = byte_i[3:0];
    end else if ((byte_i >= ChUpA) && (byte_i <= ChUpF)) begin
      hex_d = byte_i[3:0] + 4'd9;
    end else if ((byte_i >= ChA) && (byte_i <= ChLoF)) begin
      hex_d = byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign hex_acc = {value_q[3:0], hex_d};
  assign dec_acc = {value_q[4:0], 3'b000} + {value_q[6:0], 1'b0} + {4'b0000, dec_d};

  // next state
  always_comb begin
    mode_d  = mode_q;
    value_d = value_q;
    count_d = count_q;
    case (mode_q)
      MODE_TEXT: begin
        if (byte_i == ChBslash) mode_d = MODE_ESC;
      end
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        if (byte_i == ChX) begin
          mode_d  = MODE_HEX;
          value_d = 8'd0;
          count_d = 2'd0;
        end else if (is_dec) begin
          mode_d  = MODE_DEC;
          value_d = {4'b0000, dec_d};
          count_d = 2'd1;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          value_d = hex_acc;
          count_d = count_q + 2'd1;
          mode_d  = (count_q == 2'd1) ? MODE_TEXT : MODE_HEX;
        end else begin
          mode_d = (byte_i == ChBslash) ? MODE_ESC : MODE_TEXT;
        end
      end
      MODE_DEC: begin
        if (is_dec) begin
          value_d = dec_acc;
          count_d = count_q + 2'd1;
          mode_d  = (count_q == 2'd2) ? MODE_TEXT : MODE_DEC;
        end else begin
          mode_d = (byte_i == ChBslash) ? MODE_ESC : MODE_TEXT;
        end
      end
      default: mode_d = MODE_TEXT;
    endcase
    if (byte_i == ChNul) begin
      mode_d  = MODE_TEXT;
      value_d = 8'd0;
      count_d = 2'd0;
    end
  end

  // results
  always_comb begin
    k0_byte = 1'b0;
    k0_end  = 1'b0;
    k1_byte = 1'b0;
    k1_end  = 1'b0;
    b0      = 8'd0;
    b1      = 8'd0;
    case (mode_q)
      MODE_TEXT: begin
        if (byte_i == ChNul) begin
          k0_end = 1'b1;
        end else if (byte_i != ChBslash) begin
          k0_byte = 1'b1;
          b0      = byte_i;
        end
      end
      MODE_ESC: begin
        if (byte_i == ChNul) begin
          k0_byte = 1'b1;
          k1_end  = 1'b1;
        end else if ((byte_i != ChX) && !is_dec) begin
          k0_byte = 1'b1;
          case (byte_i)
            ChT:     b0 = CodeTab;
            ChN:     b0 = CodeLf;
            ChR:     b0 = CodeCr;
            ChB:     b0 = CodeBs;
            ChF:     b0 = CodeFf;
            ChA:     b0 = CodeBel;
            default: b0 = byte_i;
          endcase
        end
      end
      MODE_HEX, MODE_DEC: begin
        if ((mode_q == MODE_HEX) ? is_hex : is_dec) begin
          if ((mode_q == MODE_HEX) ? (count_q == 2'd1) : (count_q == 2'd2)) begin
            k0_byte = 1'b1;
            b0      = (mode_q == MODE_HEX) ? hex_acc : dec_acc;
          end
        end else begin
          // flush pending escape, then take the word as plain text
          k0_byte = 1'b1;
          b0      = ((mode_q == MODE_HEX) && (count_q == 2'd0)) ? ChX : value_q;
          if (byte_i == ChNul) begin
            k1_end = 1'b1;
          end else if (byte_i != ChBslash) begin
            k1_byte = 1'b1;
            b1      = byte_i;
          end
        end
      end
      default: k0_byte = 1'b0;
    endcase
  end

  assign len0    = k0_byte ? sat_inc(bytes_q) : bytes_q;
  assign len1    = k1_byte ? sat_inc(len0) : len0;
  assign bytes_d = (k0_end || k1_end) ? 16'd0 : len1;

  always_comb begin
    push_o.r0 = '{length: len0, last: k0_end, has_byte: k0_byte, data: b0};
    push_o.r1 = '{length: len1, last: k1_end, has_byte: k1_byte, data: b1};
    push_o.n  = 2'd0;
    if (accept_i) begin
      push_o.n = {1'b0, k0_byte | k0_end} + {1'b0, k1_byte | k1_end};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      value_q <= 8'd0;
      count_q <= 2'd0;
      bytes_q <= 16'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      value_q <= value_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (byte_i == ChNul)) |=> ((bytes_q == 16'd0) && (mode_q == MODE_TEXT)))
    else $error("terminator did not clear decode state");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd2) |-> (push_o.r0.has_byte && !push_o.r0.last))
    else $error("end marker not last in result pair");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= CountCap)
    else $error("byte count above cap");

endmodule

// ===== rtl/esd_out_queue.sv =====
// esd_out_queue: four-word result queue, up to two writes and one read per cycle
// separates the decoder from output stalls
// depends on esd_pkg
module esd_out_queue import esd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign valid_o = count_q != '0;
  assign room_o  = count_q <= CntW'(Depth - 2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  assign count_d = count_q + CntW'(push_i.n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_i.n);
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + PtrW'(1)] <= push_i.r1;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("push without room");

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// escape_sequence_decoder: backslash escape decoder, top level
// input slave stream of text bytes, output master stream of decoded words
// depends on esd_pkg, esd_decode, esd_out_queue
//
// One text byte per input word on s_axis; a zero byte ends the string.
// Each decoded byte leaves on m_axis with tuser high and the running
// length in tdata; the terminator gives a word with tuser low, tlast high
// and the total length, which saturates at LENGTH_MAX (at most 65535).
// An input word is decoded in the cycle it is accepted; its results are
// written into the output queue, which feeds m_axis. Throughput is one
// input word per cycle while the queue has room. A flushed hex or decimal
// escape followed by any byte but a backslash, and a backslash before the
// terminator, give two output words, which drain one per cycle through a
// four-word queue while the receiver is ready.
// s_axis_tready drops while fewer than two queue slots are free, so a
// stalled receiver fills the queue and then holds off the sender.
// Reset empties the queue and returns the decoder to plain text with a
// length of zero.
module escape_sequence_decoder import esd_pkg::*; #(
  parameter int unsigned LENGTH_MAX = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_byte [7:0], out_length [23:8]
  output logic        m_axis_tuser,  // has_byte
  output logic        m_axis_tlast   // out_last
);

  push_t   push;
  result_t head;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  esd_decode #(
    .LENGTH_MAX(LENGTH_MAX)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .push_o  (push)
  );

  esd_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (head)
  );

  assign m_axis_tdata = {head.length, head.data};
  assign m_axis_tuser = head.has_byte;
  assign m_axis_tlast = head.last;

endmodule

// ===== sim/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// tb_escape_sequence_decoder: self-checking bench for the escape sequence decoder
// streams text bytes in, predicts every decoded word and checks m_axis against it
// depends on esd_pkg and escape_sequence_decoder
module tb_escape_sequence_decoder;
  import esd_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 600_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam logic [15:0] LENGTH_CAP    = 16'hFFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_B      = "b";
  localparam logic [7:0] CH_F      = "f";
  localparam logic [7:0] CH_A      = "a";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_UA     = "A";
  localparam logic [7:0] CH_UF     = "F";
  localparam logic [7:0] CH_LA     = "a";
  localparam logic [7:0] CH_LF     = "f";

  localparam logic [7:0] CODE_TAB  = 8'd9;
  localparam logic [7:0] CODE_LF   = 8'd10;
  localparam logic [7:0] CODE_CR   = 8'd13;
  localparam logic [7:0] CODE_BS   = 8'd8;
  localparam logic [7:0] CODE_FF   = 8'd12;
  localparam logic [7:0] CODE_BEL  = 8'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  logic [7:0]  text_queue[$];
  result_t     decoded_words_due[$];

  mode_e       esc_mode = MODE_TEXT;
  logic [7:0]  esc_value = 8'h00;
  logic [1:0]  esc_digits = 2'd0;
  logic [15:0] string_length = 16'd0;

  int          send_gap_pct = 8;
  int          recv_stall_pct = 74;
  logic        rx_hold = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned words_checked = 0;
  int unsigned strings_ended = 0;
  string       hex_chars = "0123456789abcdefABCDEF";
  string       simple_escapes = "tnrbfa\\'\"";

  escape_sequence_decoder #(
    .LENGTH_MAX(65535)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder prediction

  function automatic void emit_decoded(logic [7:0] b);
    if (string_length != LENGTH_CAP) string_length++;
    decoded_words_due.push_back(result_t'{length: string_length, last: 1'b0,
                                          has_byte: 1'b1, data: b});
  endfunction

  function automatic void end_string();
    decoded_words_due.push_back(result_t'{length: string_length, last: 1'b1,
                                          has_byte: 1'b0, data: 8'h00});
    strings_ended++;
    esc_mode = MODE_TEXT;
    esc_value = 8'h00;
    esc_digits = 2'd0;
    string_length = 16'd0;
  endfunction

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == CH_NUL) end_string();
    else if (c == CH_BSLASH) esc_mode = MODE_ESC;
    else emit_decoded(c);
  endfunction

  function automatic void decode_text_byte(logic [7:0] c);
    int d;
    case (esc_mode)
      MODE_ESC: begin
        esc_mode = MODE_TEXT;
        case (c)
          CH_NUL: begin
            emit_decoded(8'h00);
            end_string();
          end
          CH_X: begin
            esc_mode = MODE_HEX;
            esc_value = 8'h00;
            esc_digits = 2'd0;
          end
          CH_T: emit_decoded(CODE_TAB);
          CH_N: emit_decoded(CODE_LF);
          CH_R: emit_decoded(CODE_CR);
          CH_B: emit_decoded(CODE_BS);
          CH_F: emit_decoded(CODE_FF);
          CH_A: emit_decoded(CODE_BEL);
          default: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              esc_mode = MODE_DEC;
              esc_value = c - CH_ZERO;
              esc_digits = 2'd1;
            end else begin
              emit_decoded(c);
            end
          end
        endcase
      end
      MODE_HEX: begin
        d = hex_digit_value(c);
        if (d >= 0) begin
          esc_value = {esc_value[3:0], 4'(d)};
          esc_digits++;
          if (esc_digits >= 2'd2) begin
            esc_mode = MODE_TEXT;
            emit_decoded(esc_value);
          end
        end else begin
          emit_decoded(esc_digits == 2'd0 ? CH_X : esc_value);
          esc_mode = MODE_TEXT;
          take_plain(c);
        end
      end
      MODE_DEC: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          esc_value = 8'(esc_value * 8'd10 + (c - CH_ZERO));
          esc_digits++;
          if (esc_digits >= 2'd3) begin
            esc_mode = MODE_TEXT;
            emit_decoded(esc_value);
          end
        end else begin
          emit_decoded(esc_value);
          esc_mode = MODE_TEXT;
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
  endfunction

  // sender

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_text_byte(s_axis_tdata);
        void'(text_queue.pop_front());
        bytes_accepted++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= text_queue[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'{length: m_axis_tdata[23:8], last: m_axis_tlast,
                         has_byte: m_axis_tuser, data: m_axis_tdata[7:0]};
        words_checked++;
        if (decoded_words_due.size() == 0) begin
          $error("word with nothing due: byte %0h length %0d", seen.data, seen.length);
          fail_count++;
        end else begin
          want = decoded_words_due.pop_front();
          if (seen.data != want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, seen.data);
            fail_count++;
          end
          if (seen.has_byte != want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, seen.has_byte);
            fail_count++;
          end
          if (seen.last != want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, seen.last);
            fail_count++;
          end
          if (seen.length != want.length) begin
            $error("out_length: expected %0d, got %0d", want.length, seen.length);
            fail_count++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the output queue fills and tready drops
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) text_queue.push_back(s[i]);
  endtask

  task automatic push_random_strings(int unsigned n_items);
    int unsigned added;
    int unsigned tokens;
    int unsigned pick;
    int unsigned start;
    logic [7:0]  b;
    added = 0;
    while (added < n_items) begin
      start = text_queue.size();
      tokens = $urandom_range(0, 10);
      for (int unsigned k = 0; k < tokens; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          b = 8'($urandom_range(1, 254));
          if (b >= CH_BSLASH) b++;
          text_queue.push_back(b);
        end else if (pick < 45) begin
          text_queue.push_back(CH_BSLASH);
          text_queue.push_back(simple_escapes[$urandom_range(0, simple_escapes.len() - 1)]);
        end else if (pick < 63) begin
          text_queue.push_back(CH_BSLASH);
          text_queue.push_back(CH_X);
          repeat ($urandom_range(0, 2))
            text_queue.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end else if (pick < 80) begin
          text_queue.push_back(CH_BSLASH);
          repeat ($urandom_range(1, 3))
            text_queue.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick < 90) begin
          text_queue.push_back(CH_BSLASH);
          text_queue.push_back(8'($urandom_range(1, 255)));
        end else begin
          // noise: any byte, a terminator included
          text_queue.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) == 0) text_queue.push_back(CH_BSLASH);
      text_queue.push_back(CH_NUL);
      added += text_queue.size() - start;
    end
  endtask

  task automatic wait_drained();
    while (text_queue.size() != 0 || decoded_words_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_queue.push_back(CH_NUL);
    push_text("\\xA\\xfF\\x\\999\\7z\\X");
    text_queue.push_back(8'hFF);
    text_queue.push_back(8'h01);
    text_queue.push_back(CH_BSLASH);
    text_queue.push_back(CH_NUL);
    push_random_strings(PHASE_ITEMS);
    wait_drained();

    send_gap_pct   <= 74;
    recv_stall_pct <= 8;
    push_random_strings(PHASE_ITEMS);
    wait_drained();

    send_gap_pct   <= 0;
    recv_stall_pct <= 0;
    @(posedge clk_i);
    push_random_strings(PHASE_ITEMS);
    hold_request = 1'b1;
    wait_drained();

    push_text("\\n\\101\\x4");
    text_queue.push_back(CH_NUL);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d text bytes in %0d strings, %0d decoded words checked",
             bytes_accepted, strings_ended, words_checked);
    $display("escapes, flushes and terminators ran under both idling mixes and a long stall");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
